[hdl/ehd_pkg.sv]
// Package for the envelope header decoder: header layout constants, item
// classes and the word type that travels from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package ehd_pkg;

  // Header layout and limits
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned MAX_ID_LEN   = 64;

  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] POS_VER_HI  = 16'd4;
  localparam logic [15:0] POS_VER_LO  = 16'd5;
  localparam logic [15:0] POS_HSZ_HI  = 16'd6;
  localparam logic [15:0] POS_HSZ_LO  = 16'd7;
  localparam logic [15:0] POS_BLEN_HI = 16'd8;
  localparam logic [15:0] POS_BLEN_LO = 16'd9;
  localparam logic [15:0] POS_CLEN_HI = 16'd10;
  localparam logic [15:0] POS_CLEN_LO = 16'd11;
  localparam logic [15:0] POS_RSVD    = 16'd12;
  localparam logic [15:0] POS_REQ     = 16'd16;
  localparam logic [15:0] POS_BODY    = 16'(HEADER_BYTES);

  localparam logic [15:0] HEADER_SIZE  = 16'(HEADER_BYTES);
  localparam logic [15:0] ID_LEN_LIMIT = 16'(MAX_ID_LEN);
  localparam logic [15:0] VERSION_RST  = 16'd1;

  // "TFBR"
  localparam logic [7:0] MAGIC [4] = '{8'h54, 8'h46, 8'h42, 8'h52};

  // Queue between front and back end
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // What a byte means, by its place in the message
  typedef enum logic [3:0] {
    KIND_CHECK,    // magic or reserved byte, checked in the front end
    KIND_HOLD,     // high byte of a 16-bit field
    KIND_VERSION,
    KIND_HSIZE,
    KIND_BLEN,
    KIND_CLEN,
    KIND_REQ,
    KIND_BODY
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] pos;
    logic [7:0]  data;
    logic        last;
    logic        bad;   // stateless check failed on this byte
  } item_t;

endpackage

[hdl/ehd_front.sv]
// Front end: accepts message bytes, tracks the byte position and classifies
// each byte. Depends on ehd_pkg.
`timescale 1ns / 1ps

module ehd_front import ehd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       push_o,
  output item_t      item_o,
  input  logic       full_i
);

  logic [15:0] pos_q, pos_d;
  logic        accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // Saturating position, back to zero after the final byte
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (last_byte_i) begin
        pos_d = '0;
      end else if (pos_q != POS_MAX) begin
        pos_d = pos_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Classification and the checks that need no state
  always_comb begin
    item_o.pos  = pos_q;
    item_o.data = data_byte_i;
    item_o.last = last_byte_i;
    item_o.kind = KIND_BODY;
    item_o.bad  = (pos_q == POS_MAX);
    if (pos_q < POS_VER_HI) begin
      item_o.kind = KIND_CHECK;
      if (data_byte_i != MAGIC[pos_q[1:0]]) item_o.bad = 1'b1;
    end else if (pos_q == POS_VER_HI || pos_q == POS_HSZ_HI ||
                 pos_q == POS_BLEN_HI || pos_q == POS_CLEN_HI) begin
      item_o.kind = KIND_HOLD;
    end else if (pos_q == POS_VER_LO) begin
      item_o.kind = KIND_VERSION;
    end else if (pos_q == POS_HSZ_LO) begin
      item_o.kind = KIND_HSIZE;
    end else if (pos_q == POS_BLEN_LO) begin
      item_o.kind = KIND_BLEN;
    end else if (pos_q == POS_CLEN_LO) begin
      item_o.kind = KIND_CLEN;
    end else if (pos_q < POS_REQ) begin
      item_o.kind = KIND_CHECK;
      if (data_byte_i != 8'd0) item_o.bad = 1'b1;
    end else if (pos_q < POS_BODY) begin
      item_o.kind = KIND_REQ;
    end
  end

endmodule

[hdl/ehd_queue.sv]
// Short queue of classified words between front and back end.
// Depends on ehd_pkg.
`timescale 1ns / 1ps

module ehd_queue import ehd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) return '0;
    return p + QPTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_next(wr_q);
      if (pop_i)  rd_q <= ptr_next(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

[hdl/ehd_back.sv]
// Back end: holds the message state, applies the stateful header checks,
// places identifier bytes and builds the verdict into the output register.
// Depends on ehd_pkg.
`timescale 1ns / 1ps

module ehd_back import ehd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        id_valid_o,
  output logic        which_id_o,
  output logic [7:0]  id_byte_o,
  output logic        done_res_o,
  output logic        status_o,
  output logic [63:0] request_id_out_o,
  output logic [15:0] broker_len_out_o,
  output logic [15:0] client_len_out_o
);

  logic [15:0] version_q;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] blen_q, blen_d, clen_q, clen_d;
  logic [63:0] req_q, req_d;
  logic        err_q, err_d;
  logic        out_valid_q;

  logic [15:0] word, off;
  logic [16:0] id_end, msg_len;
  logic [17:0] exp_len;
  logic        idv, which, fin_err;

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign word        = {hold_q, item_i.data};
  assign off         = item_i.pos - POS_BODY;
  assign id_end      = {1'b0, blen_q} + {1'b0, clen_q};

  // Next message state for the word at the head of the queue
  always_comb begin
    hold_d = hold_q;
    blen_d = blen_q;
    clen_d = clen_q;
    req_d  = req_q;
    err_d  = err_q || item_i.bad;
    idv    = 1'b0;
    which  = 1'b0;
    case (item_i.kind)
      KIND_CHECK: ;
      KIND_HOLD:  hold_d = item_i.data;
      KIND_VERSION: begin
        if (word != version_q) err_d = 1'b1;
      end
      KIND_HSIZE: begin
        if (word != HEADER_SIZE) err_d = 1'b1;
      end
      KIND_BLEN: begin
        blen_d = word;
        if (word == '0 || word > ID_LEN_LIMIT) err_d = 1'b1;
      end
      KIND_CLEN: begin
        clen_d = word;
        if (word == '0 || word > ID_LEN_LIMIT) err_d = 1'b1;
      end
      KIND_REQ:   req_d = {req_q[55:0], item_i.data};
      KIND_BODY: begin
        if (off < blen_q) begin
          idv = 1'b1;
        end else if ({1'b0, off} < id_end) begin
          idv   = 1'b1;
          which = 1'b1;
        end
        if (idv && item_i.data == 8'd0) err_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Final byte: length and request id checks
  assign msg_len = {1'b0, item_i.pos} + 17'd1;
  assign exp_len = 18'(HEADER_BYTES) + {2'b0, blen_d} + {2'b0, clen_d};
  assign fin_err = err_d || ({1'b0, msg_len} != exp_len) || (req_d == '0);

  // Configuration register and message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q   <= VERSION_RST;
      hold_q      <= '0;
      blen_q      <= '0;
      clen_q      <= '0;
      req_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) version_q <= cfg_data_i;
      if (pop_o) begin
        if (item_i.last) begin
          hold_q <= '0;
          blen_q <= '0;
          clen_q <= '0;
          req_q  <= '0;
          err_q  <= 1'b0;
        end else begin
          hold_q <= hold_d;
          blen_q <= blen_d;
          clen_q <= clen_d;
          req_q  <= req_d;
          err_q  <= err_d;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      id_valid_o       <= idv;
      which_id_o       <= which;
      id_byte_o        <= idv ? item_i.data : 8'd0;
      done_res_o       <= item_i.last;
      status_o         <= item_i.last && fin_err;
      request_id_out_o <= item_i.last ? req_d : 64'd0;
      broker_len_out_o <= item_i.last ? blen_d : 16'd0;
      client_len_out_o <= item_i.last ? clen_d : 16'd0;
    end
  end

endmodule

[hdl/envelope_header_decoder.sv]
// Envelope header decoder, top level: front end, word queue, back end.
// Throughput: one byte per cycle sustained, both sides may stall freely.
// Path: an accepted byte is written into the queue, then popped into the
// back end's output register, which raises out_valid_o.
// Reset: asynchronous, active low; clears all message state and the queue,
// expected_version returns to 1. cfg_ready_o is always high.
`timescale 1ns / 1ps

module envelope_header_decoder import ehd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        id_valid_o,
  output logic        which_id_o,
  output logic [7:0]  id_byte_o,
  output logic        done_res_o,
  output logic        status_o,
  output logic [63:0] request_id_out_o,
  output logic [15:0] broker_len_out_o,
  output logic [15:0] client_len_out_o
);

  logic  push, full, pop, q_valid;
  item_t f_item, q_item;

  assign cfg_ready_o = 1'b1;

  ehd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .item_o      (f_item),
    .full_i      (full)
  );

  ehd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ehd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .valid_i          (q_valid),
    .item_i           (q_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .id_valid_o       (id_valid_o),
    .which_id_o       (which_id_o),
    .id_byte_o        (id_byte_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .request_id_out_o (request_id_out_o),
    .broker_len_out_o (broker_len_out_o),
    .client_len_out_o (client_len_out_o)
  );

endmodule

[hdl/ehd_checker.sv]
// Port-level checker for the envelope header decoder, bound to the top level.
// Depends on ehd_pkg and the top level's ports.
`timescale 1ns / 1ps

module ehd_checker import ehd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        id_valid_o,
  input logic        which_id_o,
  input logic [7:0]  id_byte_o,
  input logic        done_res_o,
  input logic        status_o,
  input logic [63:0] request_id_out_o,
  input logic [15:0] broker_len_out_o,
  input logic [15:0] client_len_out_o
);

  // A stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(id_byte_o) && $stable(done_res_o)
      && $stable(status_o) && $stable(request_id_out_o))
    else $error("result word changed while stalled");

  // Non-identifier words carry zero id fields
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !id_valid_o |-> !which_id_o && id_byte_o == 8'd0)
    else $error("id fields set without id_valid");

  // Verdict fields only on the final byte
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> !status_o && request_id_out_o == 64'd0
      && broker_len_out_o == 16'd0 && client_len_out_o == 16'd0)
    else $error("verdict fields set before the final byte");

  // An ok verdict implies legal lengths and a nonzero request id
  a_ok_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && !status_o |-> request_id_out_o != 64'd0
      && broker_len_out_o != 16'd0 && broker_len_out_o <= ID_LEN_LIMIT
      && client_len_out_o != 16'd0 && client_len_out_o <= ID_LEN_LIMIT)
    else $error("ok verdict with an illegal header");

endmodule

bind envelope_header_decoder ehd_checker u_ehd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .id_valid_o       (id_valid_o),
  .which_id_o       (which_id_o),
  .id_byte_o        (id_byte_o),
  .done_res_o       (done_res_o),
  .status_o         (status_o),
  .request_id_out_o (request_id_out_o),
  .broker_len_out_o (broker_len_out_o),
  .client_len_out_o (client_len_out_o)
);

[test/envelope_header_decoder_test.sv]
// Self-checking testbench for envelope_header_decoder: drives whole envelope
// messages byte by byte, predicts every output word and compares it.
// Depends on ehd_pkg and envelope_header_decoder.
`timescale 1ns / 1ps

module envelope_header_decoder_test;
  import ehd_pkg::*;

  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int HOLD_AT_WORD  = 300;   // output word count that starts it
  localparam int PHASE_BYTES   = 100;   // random bytes per config phase

  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  typedef struct packed {
    logic        id_valid;
    logic        which_id;
    logic [7:0]  id_byte;
    logic        done;
    logic        status;
    logic [63:0] rid_val;
    logic [15:0] blen_val;
    logic [15:0] clen_val;
  } decode_word_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_MAGIC,
    FAULT_VERSION,
    FAULT_HSIZE,
    FAULT_BLEN,
    FAULT_CLEN,
    FAULT_RSVD,
    FAULT_ZERO_RID,
    FAULT_NUL,
    FAULT_SHORT,
    FAULT_EXTRA,
    FAULT_NOISE
  } fault_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        id_valid_o;
  logic        which_id_o;
  logic [7:0]  id_byte_o;
  logic        done_res_o;
  logic        status_o;
  logic [63:0] request_id_out_o;
  logic [15:0] broker_len_out_o;
  logic [15:0] client_len_out_o;

  envelope_header_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .id_valid_o       (id_valid_o),
    .which_id_o       (which_id_o),
    .id_byte_o        (id_byte_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .request_id_out_o (request_id_out_o),
    .broker_len_out_o (broker_len_out_o),
    .client_len_out_o (client_len_out_o)
  );

  always #6 clk_i = ~clk_i;

  msg_byte_t    pending_bytes[$];
  decode_word_t expected_words[$];
  logic [7:0]   msg_buf[$];
  int           mismatches = 0;
  int           words_seen = 0;
  bit           tx_calm = 1'b0;
  bit           rx_calm = 1'b0;

  // Decoder state as the testbench tracks it
  logic [15:0] version_reg = VERSION_RST;
  logic [15:0] msg_pos = '0;
  logic [7:0]  hold_byte = '0;
  logic [15:0] brk_len = '0;
  logic [15:0] cli_len = '0;
  logic [63:0] req_id = '0;
  logic        msg_err = 1'b0;

  // Advance the tracked state by one accepted byte and queue the word it gives
  task automatic predict_byte(input logic [7:0] b, input logic last);
    decode_word_t w;
    logic [15:0]  word;
    logic [15:0]  pos_now;
    int           off;
    w = '0;
    word = {hold_byte, b};
    pos_now = msg_pos;
    if (msg_pos == POS_MAX) msg_err = 1'b1;
    if (msg_pos < POS_VER_HI) begin
      if (b != MAGIC[msg_pos[1:0]]) msg_err = 1'b1;
    end else if (msg_pos == POS_VER_HI || msg_pos == POS_HSZ_HI ||
                 msg_pos == POS_BLEN_HI || msg_pos == POS_CLEN_HI) begin
      hold_byte = b;
    end else if (msg_pos == POS_VER_LO) begin
      if (word != version_reg) msg_err = 1'b1;
    end else if (msg_pos == POS_HSZ_LO) begin
      if (word != HEADER_SIZE) msg_err = 1'b1;
    end else if (msg_pos == POS_BLEN_LO) begin
      brk_len = word;
      if (word == '0 || word > ID_LEN_LIMIT) msg_err = 1'b1;
    end else if (msg_pos == POS_CLEN_LO) begin
      cli_len = word;
      if (word == '0 || word > ID_LEN_LIMIT) msg_err = 1'b1;
    end else if (msg_pos < POS_REQ) begin
      if (b != 8'h00) msg_err = 1'b1;
    end else if (msg_pos < POS_BODY) begin
      req_id = {req_id[55:0], b};
    end else begin
      // identifier bytes are placed by whatever lengths were stored
      off = int'(msg_pos) - int'(HEADER_BYTES);
      if (off < int'(brk_len)) begin
        w.id_valid = 1'b1;
      end else if (off < int'(brk_len) + int'(cli_len)) begin
        w.id_valid = 1'b1;
        w.which_id = 1'b1;
      end
      if (w.id_valid) begin
        w.id_byte = b;
        if (b == 8'h00) msg_err = 1'b1;
      end
    end
    if (msg_pos != POS_MAX) msg_pos = msg_pos + 16'd1;
    if (last) begin
      w.done = 1'b1;
      w.status = msg_err || req_id == '0 ||
                 (int'(pos_now) + 1 != int'(HEADER_BYTES) + int'(brk_len) + int'(cli_len));
      w.rid_val = req_id;
      w.blen_val = brk_len;
      w.clen_val = cli_len;
      msg_pos = '0;
      hold_byte = '0;
      brk_len = '0;
      cli_len = '0;
      req_id = '0;
      msg_err = 1'b0;
    end
    expected_words.push_back(w);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Input side: one byte per handshake, random gap after each accepted byte unless tx_calm
  always @(posedge clk_i) begin : byte_driver
    int        tx_wait;
    logic      nxt_valid;
    msg_byte_t nb;
    nxt_valid = in_valid_i;
    if (in_valid_i && in_ready_o) begin
      predict_byte(data_byte_i, last_byte_i);
      nxt_valid = 1'b0;
      tx_wait = tx_calm ? 0 : $urandom_range(0, 11);
    end
    if (!nxt_valid && rst_ni && pending_bytes.size() > 0) begin
      if (tx_wait > 0) begin
        tx_wait--;
      end else begin
        nb = pending_bytes.pop_front();
        data_byte_i <= nb.data;
        last_byte_i <= nb.last;
        nxt_valid = 1'b1;
      end
    end
    in_valid_i <= nxt_valid;
  end

  // Output side: compare each word, stall at random unless rx_calm, hold off once for long
  always @(posedge clk_i) begin : word_monitor
    int           rx_wait;
    int           hold_left;
    bit           held;
    decode_word_t w;
    if (out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("output word with no expected word pending");
        mismatches++;
      end else begin
        w = expected_words.pop_front();
        check_field("id_valid", 64'(w.id_valid), 64'(id_valid_o));
        check_field("which_id", 64'(w.which_id), 64'(which_id_o));
        check_field("id_byte", 64'(w.id_byte), 64'(id_byte_o));
        check_field("done_res", 64'(w.done), 64'(done_res_o));
        check_field("status", 64'(w.status), 64'(status_o));
        check_field("request_id_out", w.rid_val, request_id_out_o);
        check_field("broker_len_out", 64'(w.blen_val), 64'(broker_len_out_o));
        check_field("client_len_out", 64'(w.clen_val), 64'(client_len_out_o));
      end
      words_seen++;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
    end
    if (!held && words_seen >= HOLD_AT_WORD) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin : stall_watch
    int idle_cycles;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("envelope_header_decoder_test NOT OK");
      $finish;
    end
  end

  // Message building
  task automatic frame_header(input logic [15:0] ver, input logic [15:0] blen,
                              input logic [15:0] clen, input logic [63:0] rid);
    msg_buf.delete();
    for (int i = 0; i < 4; i++) msg_buf.push_back(MAGIC[i]);
    msg_buf.push_back(ver[15:8]);
    msg_buf.push_back(ver[7:0]);
    msg_buf.push_back(HEADER_SIZE[15:8]);
    msg_buf.push_back(HEADER_SIZE[7:0]);
    msg_buf.push_back(blen[15:8]);
    msg_buf.push_back(blen[7:0]);
    msg_buf.push_back(clen[15:8]);
    msg_buf.push_back(clen[7:0]);
    repeat (4) msg_buf.push_back(8'h00);
    for (int i = 7; i >= 0; i--) msg_buf.push_back(rid[8*i +: 8]);
  endtask

  task automatic frame_ids(input int n);
    repeat (n) msg_buf.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic frame_send();
    msg_byte_t nb;
    for (int i = 0; i < msg_buf.size(); i++) begin
      nb.data = msg_buf[i];
      nb.last = (i == msg_buf.size() - 1);
      pending_bytes.push_back(nb);
    end
  endtask

  function automatic logic [63:0] rand_rid();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return (r == '0) ? 64'h1 : r;
  endfunction

  function automatic int rand_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_ID_LEN) : $urandom_range(1, 6);
  endfunction

  // Mostly well-formed messages with random content, the rest broken or noise
  task automatic random_msg();
    int          blen;
    int          clen;
    int          k;
    logic [15:0] bad_len;
    fault_e      fault;
    blen = rand_len();
    clen = rand_len();
    fault = ($urandom_range(0, 9) < 6) ? FAULT_NONE
                                       : fault_e'($urandom_range(FAULT_MAGIC, FAULT_NOISE));
    frame_header(version_reg, 16'(blen), 16'(clen), rand_rid());
    frame_ids(blen + clen);
    bad_len = ($urandom_range(0, 2) == 0) ? 16'h0000 :
              ($urandom_range(0, 1) == 0) ? ID_LEN_LIMIT + 16'd1 : 16'($urandom);
    if (bad_len >= 16'd1 && bad_len <= ID_LEN_LIMIT) bad_len = 16'h0000;
    case (fault)
      FAULT_MAGIC: begin
        k = $urandom_range(0, 3);
        msg_buf[k] = msg_buf[k] ^ 8'($urandom_range(1, 255));
      end
      FAULT_VERSION: msg_buf[5] = msg_buf[5] ^ 8'($urandom_range(1, 255));
      FAULT_HSIZE: msg_buf[6 + $urandom_range(0, 1)] = 8'($urandom_range(25, 255));
      FAULT_BLEN: begin
        msg_buf[8] = bad_len[15:8];
        msg_buf[9] = bad_len[7:0];
      end
      FAULT_CLEN: begin
        msg_buf[10] = bad_len[15:8];
        msg_buf[11] = bad_len[7:0];
      end
      FAULT_RSVD: msg_buf[12 + $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
      FAULT_ZERO_RID: for (int i = 16; i < 24; i++) msg_buf[i] = 8'h00;
      FAULT_NUL: msg_buf[24 + $urandom_range(0, blen + clen - 1)] = 8'h00;
      FAULT_SHORT: begin
        k = $urandom_range(1, msg_buf.size() - 1);
        repeat (k) void'(msg_buf.pop_back());
      end
      FAULT_EXTRA: repeat ($urandom_range(1, 5)) msg_buf.push_back(8'($urandom_range(0, 255)));
      FAULT_NOISE: begin
        msg_buf.delete();
        repeat ($urandom_range(1, 40)) msg_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    frame_send();
  endtask

  // Header extremes, every check but position overflow and each corner of the verdict
  task automatic directed_msgs();
    // shortest identifiers, smallest request id
    frame_header(version_reg, 16'd1, 16'd1, 64'h1);
    frame_ids(2);
    frame_send();
    // longest identifiers, all-ones request id
    frame_header(version_reg, ID_LEN_LIMIT, ID_LEN_LIMIT, '1);
    frame_ids(2 * MAX_ID_LEN);
    msg_buf[24] = 8'hFF;
    frame_send();
    // bad magic
    frame_header(version_reg, 16'd2, 16'd2, rand_rid());
    frame_ids(4);
    msg_buf[3] = 8'h00;
    frame_send();
    // version mismatch
    frame_header(version_reg ^ 16'h0001, 16'd2, 16'd2, rand_rid());
    frame_ids(4);
    frame_send();
    // wrong header size
    frame_header(version_reg, 16'd2, 16'd2, rand_rid());
    frame_ids(4);
    msg_buf[7] = 8'd25;
    frame_send();
    // zero broker length
    frame_header(version_reg, 16'd0, 16'd3, rand_rid());
    frame_ids(3);
    frame_send();
    // client length one over the limit, bytes still placed by it
    frame_header(version_reg, 16'd2, ID_LEN_LIMIT + 16'd1, rand_rid());
    frame_ids(2 + MAX_ID_LEN + 1);
    frame_send();
    // largest lengths, short body
    frame_header(version_reg, 16'hFFFF, 16'hFFFF, rand_rid());
    frame_ids(10);
    frame_send();
    // reserved word not zero
    frame_header(version_reg, 16'd3, 16'd1, rand_rid());
    frame_ids(4);
    msg_buf[15] = 8'h80;
    frame_send();
    // zero request id
    frame_header(version_reg, 16'd3, 16'd2, 64'h0);
    frame_ids(5);
    frame_send();
    // NUL inside the client id
    frame_header(version_reg, 16'd2, 16'd3, rand_rid());
    frame_ids(5);
    msg_buf[msg_buf.size() - 1] = 8'h00;
    frame_send();
    // one-byte message
    msg_buf.delete();
    msg_buf.push_back(MAGIC[0]);
    frame_send();
    // truncated header
    frame_header(version_reg, 16'd1, 16'd1, rand_rid());
    repeat (4) void'(msg_buf.pop_back());
    frame_send();
    // surplus bytes after the identifiers
    frame_header(version_reg, 16'd1, 16'd2, rand_rid());
    frame_ids(6);
    frame_send();
    // header alone
    frame_header(version_reg, 16'd1, 16'd1, rand_rid());
    frame_send();
    // clean message after all the errors
    frame_header(version_reg, 16'd4, 16'd4, rand_rid());
    frame_ids(8);
    frame_send();
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_version(input logic [15:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    version_reg = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Sequence: reset, directed messages, random phases per version
  initial begin : stimulus
    int          phase_start;
    logic [15:0] v;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_msgs();
    wait_drained();
    for (int ph = 0; ph < 7; ph++) begin
      v = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF :
          (ph == 6) ? VERSION_RST : 16'($urandom);
      write_version(v);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      phase_start = pending_bytes.size();
      while (pending_bytes.size() - phase_start < PHASE_BYTES) random_msg();
      wait_drained();
    end
    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("envelope_header_decoder_test OK");
    else
      $display("envelope_header_decoder_test NOT OK");
    $finish;
  end

endmodule
